// ===== design/gnss_dual_antenna_bearing_assert.svh =====
// assertion macros used by the bearing rtl file
`ifndef GNSS_DUAL_ANTENNA_BEARING_ASSERT_SVH
`define GNSS_DUAL_ANTENNA_BEARING_ASSERT_SVH
`ifndef SYNTHESIS
`define GDAB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gdab assertion failed");
`define GDAB_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("gdab forbidden condition");
`else
`define GDAB_ASSERT(lbl, clk, rst, prop)
`define GDAB_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== design/gdab_pkg.sv =====
`timescale 1ns / 1ps
package gdab_pkg;
   localparam int XY_W = 35;
   localparam int Z_W  = 34;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
   localparam logic [40:0] DEG_SCALE = 41'd360;
   localparam logic [32:0] BAM_RECIP = 33'd5124095576;
   localparam logic [31:0] BAM_DIV = 32'd3600000000;
   localparam logic [64:0] BAM_HALF = 65'd1800000000;
   localparam logic signed [26:0] RAD_MIN = -27'sd52707179;
   localparam logic signed [26:0] RAD_MAX = 27'sd52707178;
   localparam logic signed [27:0] DEG_SPAN = 28'sd23592960;

   // arctangent of 2^-idx in binary angle units
   function automatic logic [31:0] atan_entry(input int unsigned idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'd536870912;  1: v = 32'd316933406;  2: v = 32'd167458907;
         3: v = 32'd85004756;   4: v = 32'd42667331;   5: v = 32'd21354465;
         6: v = 32'd10679838;   7: v = 32'd5340245;    8: v = 32'd2670163;
         9: v = 32'd1335087;    10: v = 32'd667544;    11: v = 32'd333772;
         12: v = 32'd166886;    13: v = 32'd83443;     14: v = 32'd41722;
         15: v = 32'd20861;     16: v = 32'd10430;     17: v = 32'd5215;
         18: v = 32'd2608;      19: v = 32'd1304;      20: v = 32'd652;
         21: v = 32'd326;       22: v = 32'd163;       23: v = 32'd81;
         24: v = 32'd41;        25: v = 32'd20;        26: v = 32'd10;
         27: v = 32'd5;         28: v = 32'd3;         29: v = 32'd1;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage

// ===== design/gdab_bam.sv =====
`timescale 1ns / 1ps
module gdab_bam #(
   parameter int IN_W = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [IN_W-1:0] in_coord,
   output logic                   out_valid,
   output logic [31:0]            out_bam
);
   import gdab_pkg::*;

   logic [4:0]  valid_ff;
   logic [3:0]  neg_ff;
   logic [31:0] m1_ff, m2_ff, m3_ff;
   logic [64:0] p_ff, p_in;
   logic [32:0] q0_ff, q0a_ff;
   logic [64:0] prod_ff, prod_in;
   logic [64:0] n_in;
   logic [35:0] r_ff, r_in;
   logic [31:0] bam_ff, bam_in;
   logic signed [32:0] ext;
   logic [31:0] mag;
   logic [1:0]  corr;
   logic [32:0] q;

   always_comb begin
      ext = 33'(in_coord);
      mag = ext[32] ? 32'(-ext) : ext[31:0];
      p_in = 65'(m1_ff) * 65'(BAM_RECIP);
      prod_in = 65'(p_ff[64:32]) * 65'(BAM_DIV);
      n_in = {1'b0, m3_ff, 32'd0} + BAM_HALF;
      r_in = 36'(n_in - prod_ff);
      // reciprocal estimate is low by at most three
      corr = 2'd0;
      if (r_ff >= 36'(3 * 64'(BAM_DIV)))      corr = 2'd3;
      else if (r_ff >= 36'(2 * 64'(BAM_DIV))) corr = 2'd2;
      else if (r_ff >= 36'(BAM_DIV))          corr = 2'd1;
      q = q0a_ff + 33'(corr);
      bam_in = neg_ff[3] ? (32'd0 - q[31:0]) : q[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
      if (en) begin
         neg_ff  <= {neg_ff[2:0], ext[32]};
         m1_ff   <= mag;
         p_ff    <= p_in;
         m2_ff   <= m1_ff;
         q0_ff   <= p_ff[64:32];
         prod_ff <= prod_in;
         m3_ff   <= m2_ff;
         r_ff    <= r_in;
         q0a_ff  <= q0_ff;
         bam_ff  <= bam_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_bam   = bam_ff;
endmodule

// ===== design/gdab_rot_cell.sv =====
`timescale 1ns / 1ps
module gdab_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [gdab_pkg::XY_W-1:0] in_x,
   input  logic signed [gdab_pkg::XY_W-1:0] in_y,
   input  logic signed [gdab_pkg::Z_W-1:0]  in_z,
   input  logic                            in_neg,
   output logic                            out_valid,
   output logic signed [gdab_pkg::XY_W-1:0] out_x,
   output logic signed [gdab_pkg::XY_W-1:0] out_y,
   output logic signed [gdab_pkg::Z_W-1:0]  out_z,
   output logic                            out_neg
);
   import gdab_pkg::*;

   logic valid_ff, neg_ff;
   logic signed [XY_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in, step;

   always_comb begin
      step = Z_W'(atan_entry(STAGE));
      if (in_z >= 0) begin
         x_in = in_x - (in_y >>> STAGE);
         y_in = in_y + (in_x >>> STAGE);
         z_in = in_z - step;
      end else begin
         x_in = in_x + (in_y >>> STAGE);
         y_in = in_y - (in_x >>> STAGE);
         z_in = in_z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         neg_ff <= in_neg;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_neg   = neg_ff;
endmodule

// ===== design/gdab_vec_cell.sv =====
`timescale 1ns / 1ps
module gdab_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [gdab_pkg::XY_W-1:0] in_x,
   input  logic signed [gdab_pkg::XY_W-1:0] in_y,
   input  logic signed [gdab_pkg::Z_W-1:0]  in_z,
   input  logic                            in_zero,
   output logic                            out_valid,
   output logic signed [gdab_pkg::XY_W-1:0] out_x,
   output logic signed [gdab_pkg::XY_W-1:0] out_y,
   output logic signed [gdab_pkg::Z_W-1:0]  out_z,
   output logic                            out_zero
);
   import gdab_pkg::*;

   logic valid_ff, zero_ff;
   logic signed [XY_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in, step;

   always_comb begin
      step = Z_W'(atan_entry(STAGE));
      if (in_y >= 0) begin
         x_in = in_x + (in_y >>> STAGE);
         y_in = in_y - (in_x >>> STAGE);
         z_in = in_z + step;
      end else begin
         x_in = in_x - (in_y >>> STAGE);
         y_in = in_y + (in_x >>> STAGE);
         z_in = in_z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_zero  = zero_ff;
endmodule

// ===== design/gnss_dual_antenna_bearing.sv =====
`timescale 1ns / 1ps
// Great-circle initial bearing between two antenna positions, plus a quarter
// turn, as Q16 degrees (with mounting offset) and Q24 radians. Fully pipelined:
// one position pair is taken every clock while the result output is not
// stalled; each pair passes through the staged coordinate conversion, the
// rotation CORDIC cell rows for sine and cosine, and the vectoring row for atan2.
// A stalled result output holds the whole pipeline.
`include "gnss_dual_antenna_bearing_assert.svh"
module gnss_dual_antenna_bearing #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // main_latitude, main_longitude, aux_latitude, aux_longitude, zero pad
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // heading_degrees, heading_radians, zero pad
   output logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [25:0]  csr_wdata
);
   import gdab_pkg::*;

   localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   logic en;
   logic signed [25:0] offset_ff;
   logic [3:0]  bv;
   logic [31:0] bam [4];

   // rotation rows: 0 lat1, 1 lat2, 2 delta lon
   logic                   rv [3][NST+1];
   logic signed [XY_W-1:0] rx [3][NST+1];
   logic signed [XY_W-1:0] ry [3][NST+1];
   logic signed [Z_W-1:0]  rz [3][NST+1];
   logic                   rn [3][NST+1];

   logic                   vv [NST+1];
   logic signed [XY_W-1:0] vx [NST+1];
   logic signed [XY_W-1:0] vy [NST+1];
   logic signed [Z_W-1:0]  vz [NST+1];
   logic                   vzero [NST+1];

   logic p_v_ff;
   logic signed [Z_W-1:0] pz_ff [3];
   logic pn_ff [3];
   logic signed [31:0] zs [3];
   logic [31:0] ang [3];

   logic s_v_ff;
   logic signed [31:0] sn_ff [3];
   logic signed [31:0] cs_ff [3];

   logic m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, vp_v_ff, o1_v_ff, rsp_v_ff;
   logic signed [63:0] py_ff, pt_ff, pa_ff, pb_ff;
   logic signed [31:0] cd1_ff, cd2_ff;
   logic signed [33:0] yv2_ff, yv3_ff, tmp_ff, a2_ff, a3_ff;
   logic signed [XY_W-1:0] xv_ff, yv_ff;
   logic signed [XY_W-1:0] vx0_ff, vy0_ff;
   logic signed [Z_W-1:0]  vz0_ff;
   logic vzero0_ff;
   logic [31:0] b;
   logic [40:0] degp_ff;
   logic signed [63:0] radp_ff;
   logic signed [26:0] deg_ff, rad_ff, deg_in, rad_in;
   logic signed [31:0] b_s;

   assign en = !rsp_v_ff || rsp_tready;
   assign req_tready = en;

   gdab_bam #(.IN_W(31)) u_lat1 (.clock, .reset, .en, .in_valid(req_tvalid),
      .in_coord(req_tdata[30:0]), .out_valid(bv[0]), .out_bam(bam[0]));
   gdab_bam #(.IN_W(32)) u_lon1 (.clock, .reset, .en, .in_valid(req_tvalid),
      .in_coord(req_tdata[62:31]), .out_valid(bv[1]), .out_bam(bam[1]));
   gdab_bam #(.IN_W(31)) u_lat2 (.clock, .reset, .en, .in_valid(req_tvalid),
      .in_coord(req_tdata[93:63]), .out_valid(bv[2]), .out_bam(bam[2]));
   gdab_bam #(.IN_W(32)) u_lon2 (.clock, .reset, .en, .in_valid(req_tvalid),
      .in_coord(req_tdata[125:94]), .out_valid(bv[3]), .out_bam(bam[3]));

   always_comb begin
      ang[0] = bam[0];
      ang[1] = bam[2];
      ang[2] = bam[3] - bam[1];
      for (int k = 0; k < 3; k++) begin
         zs[k] = $signed(ang[k]);
      end
   end

   generate
      for (genvar c = 0; c < 3; c++) begin : g_rot
         assign rv[c][0] = p_v_ff;
         assign rx[c][0] = CORDIC_GAIN;
         assign ry[c][0] = '0;
         assign rz[c][0] = pz_ff[c];
         assign rn[c][0] = pn_ff[c];
         for (genvar i = 0; i < NST; i++) begin : g_cell
            gdab_rot_cell #(.STAGE(i)) u_cell (.clock, .reset, .en,
               .in_valid(rv[c][i]), .in_x(rx[c][i]), .in_y(ry[c][i]),
               .in_z(rz[c][i]), .in_neg(rn[c][i]),
               .out_valid(rv[c][i+1]), .out_x(rx[c][i+1]), .out_y(ry[c][i+1]),
               .out_z(rz[c][i+1]), .out_neg(rn[c][i+1]));
         end
      end
   endgenerate

   assign vv[0]    = vp_v_ff;
   assign vx[0]    = vx0_ff;
   assign vy[0]    = vy0_ff;
   assign vz[0]    = vz0_ff;
   assign vzero[0] = vzero0_ff;

   generate
      for (genvar i = 0; i < NST; i++) begin : g_vec
         gdab_vec_cell #(.STAGE(i)) u_cell (.clock, .reset, .en,
            .in_valid(vv[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]),
            .in_zero(vzero[i]), .out_valid(vv[i+1]), .out_x(vx[i+1]),
            .out_y(vy[i+1]), .out_z(vz[i+1]), .out_zero(vzero[i+1]));
      end
   endgenerate

   always_comb begin
      // degenerate vector gives angle zero
      b = (vzero[NST] ? 32'd0 : vz[NST][31:0]) + QUARTER_TURN;
      b_s = $signed(b);
      deg_in = 27'(degp_ff >> 16) + 27'(offset_ff);
      rad_in = 27'(radp_ff >>> 36);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         p_v_ff    <= 1'b0;
         s_v_ff    <= 1'b0;
         m1_v_ff   <= 1'b0;
         m2_v_ff   <= 1'b0;
         m3_v_ff   <= 1'b0;
         m4_v_ff   <= 1'b0;
         vp_v_ff   <= 1'b0;
         o1_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            offset_ff <= $signed(csr_wdata);
         end
         if (en) begin
            p_v_ff   <= &bv;
            s_v_ff   <= rv[0][NST] & rv[1][NST] & rv[2][NST];
            m1_v_ff  <= s_v_ff;
            m2_v_ff  <= m1_v_ff;
            m3_v_ff  <= m2_v_ff;
            m4_v_ff  <= m3_v_ff;
            vp_v_ff  <= m4_v_ff;
            o1_v_ff  <= vv[NST];
            rsp_v_ff <= o1_v_ff;
         end
      end
      if (en) begin
         // fold into the right half plane before rotating
         for (int k = 0; k < 3; k++) begin
            if (zs[k] > 32'sh4000_0000) begin
               pz_ff[k] <= Z_W'(zs[k]) - Z_W'(64'sh8000_0000);
               pn_ff[k] <= 1'b1;
            end else if (zs[k] < -32'sh4000_0000) begin
               pz_ff[k] <= Z_W'(zs[k]) + Z_W'(64'sh8000_0000);
               pn_ff[k] <= 1'b1;
            end else begin
               pz_ff[k] <= Z_W'(zs[k]);
               pn_ff[k] <= 1'b0;
            end
            sn_ff[k] <= 32'(rn[k][NST] ? -ry[k][NST] : ry[k][NST]);
            cs_ff[k] <= 32'(rn[k][NST] ? -rx[k][NST] : rx[k][NST]);
         end
         py_ff  <= sn_ff[2] * cs_ff[1];
         pt_ff  <= sn_ff[0] * cs_ff[1];
         pa_ff  <= cs_ff[0] * sn_ff[1];
         cd1_ff <= cs_ff[2];
         yv2_ff <= 34'(py_ff >>> 30);
         tmp_ff <= 34'(pt_ff >>> 30);
         a2_ff  <= 34'(pa_ff >>> 30);
         cd2_ff <= cd1_ff;
         pb_ff  <= 32'(tmp_ff) * cd2_ff;
         yv3_ff <= yv2_ff;
         a3_ff  <= a2_ff;
         xv_ff  <= XY_W'(a3_ff) - XY_W'(pb_ff >>> 30);
         yv_ff  <= XY_W'(yv3_ff);
         vzero0_ff <= (xv_ff == 0) && (yv_ff == 0);
         if (xv_ff < 0) begin
            vx0_ff <= -xv_ff;
            vy0_ff <= -yv_ff;
            vz0_ff <= Z_W'(64'sh8000_0000);
         end else begin
            vx0_ff <= xv_ff;
            vy0_ff <= yv_ff;
            vz0_ff <= '0;
         end
         degp_ff <= 41'(b) * DEG_SCALE;
         radp_ff <= b_s * PI_Q29;
         deg_ff  <= deg_in;
         rad_ff  <= rad_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {2'b00, rad_ff, deg_ff};

   `GDAB_NEVER(a_no_take_when_held, clock, reset, rsp_tvalid && !rsp_tready && req_tready)
   `GDAB_ASSERT(a_rad_range, clock, reset,
      rsp_tvalid |-> (rad_ff >= RAD_MIN) && (rad_ff <= RAD_MAX))
   `GDAB_ASSERT(a_deg_range, clock, reset,
      rsp_tvalid |-> (28'(deg_ff) - 28'(offset_ff) >= 0)
         && (28'(deg_ff) - 28'(offset_ff) < DEG_SPAN))
endmodule
